[rtl/core/afb_pkg.sv]
package afb_pkg;

    // Batch capacity and derived widths
    localparam int BATCH_MAX     = 64;
    localparam int DEFAULT_BATCH = 20;
    localparam int FILL_W        = $clog2(BATCH_MAX + 1);
    localparam int IDX_W         = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int ADDR_W        = IDX_W + 1;
    localparam int RAM_DEPTH     = 2 ** ADDR_W;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BATCH_MAX);

    // Command codes
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_BATCH_COUNT  = 2'd0;
    localparam logic [1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SINK_ENABLED = 2'd2;

    typedef struct packed {
        logic [6:0]  batch_count;
        logic [15:0] max_interval_ms;
        logic        sink_enabled;
    } t_cfg;

    // One stored arrival record
    typedef struct packed {
        logic [15:0] frame_seq;
        logic [15:0] pkt_index;
        logic [15:0] rx_size;
        logic [31:0] offset;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Drain job handed from front to back
    typedef struct packed {
        logic              bank;
        logic [FILL_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_ram_wr;

    typedef struct packed {
        t_entry     entry;
        logic [6:0] count;
        logic       last;
    } t_rec;

endpackage

[rtl/core/afb_ram.sv]
module afb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/afb_front.sv]
module afb_front
    import afb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_fire,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_frame_seq,
    input  logic [15:0] i_pkt_index,
    input  logic [15:0] i_rx_size,
    input  logic [62:0] i_arrival_time_us,
    output t_ram_wr     o_wr,
    output logic        o_job_push,
    output t_job        o_job
);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [31:0]       r_epoch, n_epoch;
    logic              r_epoch_valid, n_epoch_valid;
    logic [31:0]       r_elapsed, n_elapsed;
    logic              r_sent_once, n_sent_once;
    logic              r_bank, n_bank;

    // Effective count threshold
    int thr;
    always_comb begin
        thr = (i_cfg.batch_count == '0) ? DEFAULT_BATCH : int'(i_cfg.batch_count);
        if (thr > BATCH_MAX) begin
            thr = BATCH_MAX;
        end
    end

    // Command decode, append and batch trigger
    always_comb begin
        logic [FILL_W-1:0] fill_a;
        logic [31:0]       el_a;
        logic [31:0]       epoch_use;
        logic              timer_on;
        logic              due;

        n_fill        = r_fill;
        n_epoch       = r_epoch;
        n_epoch_valid = r_epoch_valid;
        n_elapsed     = r_elapsed;
        n_sent_once   = r_sent_once;
        n_bank        = r_bank;

        fill_a    = r_fill;
        el_a      = r_elapsed;
        due       = 1'b0;
        timer_on  = (i_cfg.max_interval_ms != '0);
        epoch_use = r_epoch_valid ? r_epoch : i_arrival_time_us[31:0];

        o_wr.we             = 1'b0;
        o_wr.addr           = {r_bank, r_fill[IDX_W-1:0]};
        o_wr.data.frame_seq = i_frame_seq;
        o_wr.data.pkt_index = i_pkt_index;
        o_wr.data.rx_size   = i_rx_size;
        o_wr.data.offset    = i_arrival_time_us[31:0] - epoch_use;

        o_job_push = 1'b0;
        o_job.bank = r_bank;
        o_job.count = r_fill;

        if (i_fire) begin
            case (i_command)
                CMD_PACKET: begin
                    n_epoch       = epoch_use;
                    n_epoch_valid = 1'b1;
                    if (r_fill == '0 && !r_sent_once) begin
                        el_a = '0;
                    end
                    if (r_fill < FILL_MAX) begin
                        o_wr.we = 1'b1;
                        fill_a  = r_fill + 1'b1;
                    end
                    due = (int'(fill_a) >= thr) ||
                          (timer_on && el_a >= {16'b0, i_cfg.max_interval_ms});
                end
                CMD_TICK: begin
                    if (r_elapsed != '1) begin
                        el_a = r_elapsed + 32'd1;
                    end
                    due = (r_fill != '0) && timer_on &&
                          (el_a >= {16'b0, i_cfg.max_interval_ms});
                end
                CMD_FLUSH: begin
                    due = (r_fill != '0);
                end
                default: begin
                end
            endcase

            n_fill    = fill_a;
            n_elapsed = el_a;

            // Emit to the back end, or drop when the sink is off
            if (due) begin
                n_fill = '0;
                if (i_cfg.sink_enabled) begin
                    o_job_push  = 1'b1;
                    o_job.count = fill_a;
                    n_bank      = ~r_bank;
                    n_elapsed   = '0;
                    n_sent_once = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_epoch       <= '0;
            r_epoch_valid <= 1'b0;
            r_elapsed     <= '0;
            r_sent_once   <= 1'b0;
            r_bank        <= 1'b0;
        end else begin
            r_fill        <= n_fill;
            r_epoch       <= n_epoch;
            r_epoch_valid <= n_epoch_valid;
            r_elapsed     <= n_elapsed;
            r_sent_once   <= n_sent_once;
            r_bank        <= n_bank;
        end
    end

endmodule

[rtl/core/afb_jobq.sv]
module afb_jobq
    import afb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    // Two entries, one per buffer bank
    t_job       r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/core/afb_back.sv]
module afb_back
    import afb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_job_pop,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  t_entry            i_rdata,
    output t_rec              o_rec,
    output logic              o_empty,
    input  logic              i_pop
);

    logic [FILL_W-1:0] r_idx;
    logic              r_infl;
    logic [6:0]        r_infl_cnt;
    logic              r_infl_last;
    t_rec              r_buf [2];
    logic              r_wptr, r_rptr;
    logic [1:0]        r_cnt;

    logic       pop_fire;
    logic [2:0] occ;
    logic       last;

    assign pop_fire = i_pop && (r_cnt != 2'd0);
    assign occ      = {1'b0, r_cnt} + {2'b0, r_infl};
    assign last     = (r_idx == i_job.count - 1'b1);

    // Read one record when the output buffer has room for it
    assign o_re      = i_job_valid && ((occ < 3'd2) || (occ == 3'd2 && pop_fire));
    assign o_raddr   = {i_job.bank, r_idx[IDX_W-1:0]};
    assign o_job_pop = o_re && last;

    assign o_empty = (r_cnt == 2'd0);
    assign o_rec   = r_buf[r_rptr];

    // Tag data in flight and capture it in the output buffer
    always_ff @(posedge i_clk) begin
        if (o_re) begin
            r_infl_cnt  <= 7'(i_job.count);
            r_infl_last <= last;
        end
        if (r_infl) begin
            r_buf[r_wptr].entry <= i_rdata;
            r_buf[r_wptr].count <= r_infl_cnt;
            r_buf[r_wptr].last  <= r_infl_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_infl <= 1'b0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_infl <= o_re;
            if (o_re) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
            if (r_infl) begin
                r_wptr <= ~r_wptr;
            end
            if (pop_fire) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, r_infl} - {1'b0, pop_fire};
        end
    end

endmodule

[rtl/core/arrival_feedback_batcher_top.sv]
// Arrival feedback batcher. Commands (packet arrival, 1 ms tick, flush) are
// taken at one per cycle while full is low. Packets are written into one of
// two banks of a record RAM; when a batch becomes due it is queued as a drain
// job and the front switches banks, so intake goes on while the back end
// reads the earlier batch out. Records leave one per cycle through the RAM
// read port while the receiver keeps popping, by way of the registered read
// and the output buffer. full rises only while both banks hold batches not
// yet drained, so intake stalls once a second batch falls due before the
// first has been read out.
module arrival_feedback_batcher_top
    import afb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Command side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_frame_seq,
    input  logic [15:0] i_pkt_index,
    input  logic [15:0] i_rx_size,
    input  logic [62:0] i_arrival_time_us,
    // Feedback side
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_out_frame_seq,
    output logic [15:0] o_out_pkt_index,
    output logic [15:0] o_out_rx_size,
    output logic signed [31:0] o_arrival_offset_us,
    output logic [6:0]  o_batch_len,
    output logic        o_last_record
);

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    in_fire;
    t_ram_wr wr;
    logic    job_push;
    t_job    job_in;
    logic    jq_full;
    logic    jq_valid;
    t_job    jq_head;
    logic    job_pop;
    logic    ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_entry  ram_rdata;
    t_rec    rec;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.batch_count     <= 7'(DEFAULT_BATCH);
            r_cfg.max_interval_ms <= 16'd10;
            r_cfg.sink_enabled    <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BATCH_COUNT:  r_cfg.batch_count     <= pwdata[6:0];
                REG_MAX_INTERVAL: r_cfg.max_interval_ms <= pwdata[15:0];
                REG_SINK_ENABLED: r_cfg.sink_enabled    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BATCH_COUNT:  prdata = {25'b0, r_cfg.batch_count};
            REG_MAX_INTERVAL: prdata = {16'b0, r_cfg.max_interval_ms};
            REG_SINK_ENABLED: prdata = {31'b0, r_cfg.sink_enabled};
            default:          prdata = '0;
        endcase
    end

    assign full    = jq_full;
    assign in_fire = push && !jq_full;

    afb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_fire            (in_fire),
        .i_command         (i_command),
        .i_frame_seq       (i_frame_seq),
        .i_pkt_index       (i_pkt_index),
        .i_rx_size         (i_rx_size),
        .i_arrival_time_us (i_arrival_time_us),
        .o_wr              (wr),
        .o_job_push        (job_push),
        .o_job             (job_in)
    );

    afb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    afb_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (jq_full),
        .o_valid (jq_valid),
        .o_head  (jq_head)
    );

    afb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (jq_valid),
        .i_job       (jq_head),
        .o_job_pop   (job_pop),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata),
        .o_rec       (rec),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_out_frame_seq     = rec.entry.frame_seq;
    assign o_out_pkt_index     = rec.entry.pkt_index;
    assign o_out_rx_size       = rec.entry.rx_size;
    assign o_arrival_offset_us = signed'(rec.entry.offset);
    assign o_batch_len         = rec.count;
    assign o_last_record       = rec.last;

    // A job is never queued into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !jq_full)
        else $error("drain job pushed into full queue");

    // Front never writes the bank the back end is draining
    a_bank_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.we && jq_valid) |-> (wr.addr[ADDR_W-1] != jq_head.bank))
        else $error("record write into bank under drain");

    // Every presented feedback record carries a non-zero batch size
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_batch_len != 7'd0))
        else $error("feedback record with zero count");

endmodule

[test/arrival_feedback_batcher_top_test.sv]
`timescale 1ns / 100ps

module arrival_feedback_batcher_top_test;
    import afb_pkg::*;

    // Command 3 has no meaning and must leave the block untouched
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int QUIET_CYCLES    = 80;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int CFG_ROUNDS      = 12;
    localparam int ITEMS_PER_ROUND = 42;

    // One feedback record as seen on the result ports
    typedef struct {
        logic [15:0]        frame_seq;
        logic [15:0]        pkt_index;
        logic [15:0]        rx_size;
        logic signed [31:0] offset;
        logic [6:0]         count;
        logic               last;
    } t_fb_rec;

    typedef enum logic {ROW_CMD, ROW_REG} t_row_kind;

    // Directed stimulus row; typed rows carry their expectation inline
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  command;
        logic [15:0] frame_seq;
        logic [15:0] pkt_index;
        logic [15:0] rx_size;
        logic [62:0] arrival_us;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        bit          typed;
        int          typed_n;
        logic [31:0] typed_offset;
    } t_dir_row;

    // Block ports
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic        full;
    logic [1:0]  i_command         = '0;
    logic [15:0] i_frame_seq       = '0;
    logic [15:0] i_pkt_index       = '0;
    logic [15:0] i_rx_size         = '0;
    logic [62:0] i_arrival_time_us = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic [15:0] o_out_frame_seq;
    logic [15:0] o_out_pkt_index;
    logic [15:0] o_out_rx_size;
    logic signed [31:0] o_arrival_offset_us;
    logic [6:0]  o_batch_len;
    logic        o_last_record;

    arrival_feedback_batcher_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: pending batch, epoch, elapsed time, settings
    logic [15:0] pend_fs [BATCH_MAX];
    logic [15:0] pend_pi [BATCH_MAX];
    logic [15:0] pend_sz [BATCH_MAX];
    logic [31:0] pend_us [BATCH_MAX];
    int          pend_fill;
    logic [62:0] epoch_us;
    bit          epoch_set;
    logic [31:0] elapsed_ms;
    bit          batch_sent;
    logic [6:0]  cfg_batch;
    logic [15:0] cfg_interval;
    logic        cfg_sink;

    t_fb_rec  feedback_due[$];
    t_fb_rec  batch_out[$];
    t_dir_row dir_rows[$];

    int fail_count   = 0;
    int stall_cycles = 0;
    int send_idle    = 31;
    int recv_idle    = 79;
    bit hold_pop     = 1'b0;
    bit pressure_go  = 1'b0;

    function automatic int batch_threshold();
        int thr;
        thr = (cfg_batch == 7'd0) ? DEFAULT_BATCH : int'(cfg_batch);
        if (thr > BATCH_MAX) thr = BATCH_MAX;
        return thr;
    endfunction

    function automatic bit deadline_due();
        return (cfg_interval != 16'd0) && (elapsed_ms >= {16'd0, cfg_interval});
    endfunction

    // Empty the pending batch; records come out only with the sink on
    task automatic drain_pending();
        t_fb_rec rec;
        if (pend_fill != 0 && cfg_sink) begin
            for (int i = 0; i < pend_fill; i++) begin
                rec.frame_seq = pend_fs[i];
                rec.pkt_index = pend_pi[i];
                rec.rx_size   = pend_sz[i];
                rec.offset    = pend_us[i] - epoch_us[31:0];
                rec.count     = 7'(pend_fill);
                rec.last      = (i == pend_fill - 1);
                batch_out     = {batch_out, rec};
            end
            elapsed_ms = '0;
            batch_sent = 1'b1;
        end
        pend_fill = 0;
    endtask

    // Feedback records caused by one accepted command land in batch_out
    task automatic predict_feedback(input logic [1:0] cmd, input logic [15:0] fs,
                                    input logic [15:0] pi, input logic [15:0] sz,
                                    input logic [62:0] t);
        batch_out.delete();
        case (cmd)
            CMD_PACKET: begin
                if (!epoch_set) begin
                    epoch_us  = t;
                    epoch_set = 1'b1;
                end
                if (pend_fill == 0 && !batch_sent) elapsed_ms = '0;
                if (pend_fill < BATCH_MAX) begin
                    pend_fs[pend_fill] = fs;
                    pend_pi[pend_fill] = pi;
                    pend_sz[pend_fill] = sz;
                    pend_us[pend_fill] = t[31:0];
                    pend_fill++;
                end
                if (pend_fill >= batch_threshold() || deadline_due()) drain_pending();
            end
            CMD_TICK: begin
                if (elapsed_ms != '1) elapsed_ms++;
                if (pend_fill != 0 && deadline_due()) drain_pending();
            end
            CMD_FLUSH: drain_pending();
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (fail_count < MAX_REPORTS)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        fail_count++;
    endtask

    // Offer one command request, with random idle cycles ahead of it
    task automatic send_command(input logic [1:0] cmd, input logic [15:0] fs,
                                input logic [15:0] pi, input logic [15:0] sz,
                                input logic [62:0] t, input bit track);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push              <= 1'b1;
        i_command         <= cmd;
        i_frame_seq       <= fs;
        i_pkt_index       <= pi;
        i_rx_size         <= sz;
        i_arrival_time_us <= t;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_feedback(cmd, fs, pi, sz, t);
        if (track) feedback_due = {feedback_due, batch_out};
    endtask

    // Wait for every outstanding record, then let the back end go quiet
    task automatic settle_block();
        push <= 1'b0;
        while (feedback_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the same register
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BATCH_COUNT: begin
                cfg_batch = value[6:0];
                want      = {25'd0, value[6:0]};
            end
            REG_MAX_INTERVAL: begin
                cfg_interval = value[15:0];
                want         = {16'd0, value[15:0]};
            end
            REG_SINK_ENABLED: begin
                cfg_sink = value[0];
                want     = {31'd0, value[0]};
            end
            default: want = '0;
        endcase
        if (readback !== want)
            note_mismatch("register read back", 64'(want), 64'(readback));
    endtask

    task automatic add_cmd(input logic [1:0] cmd, input logic [15:0] fs,
                           input logic [15:0] pi, input logic [15:0] sz,
                           input logic [62:0] t, input bit typed, input int n,
                           input logic [31:0] offset);
        t_dir_row row;
        row.kind         = ROW_CMD;
        row.command      = cmd;
        row.frame_seq    = fs;
        row.pkt_index    = pi;
        row.rx_size      = sz;
        row.arrival_us   = t;
        row.reg_idx      = '0;
        row.reg_val      = '0;
        row.typed        = typed;
        row.typed_n      = n;
        row.typed_offset = offset;
        dir_rows         = {dir_rows, row};
    endtask

    task automatic add_reg(input logic [1:0] idx, input logic [31:0] value);
        t_dir_row row;
        row.kind         = ROW_REG;
        row.command      = '0;
        row.frame_seq    = '0;
        row.pkt_index    = '0;
        row.rx_size      = '0;
        row.arrival_us   = '0;
        row.reg_idx      = idx;
        row.reg_val      = value;
        row.typed        = 1'b0;
        row.typed_n      = 0;
        row.typed_offset = '0;
        dir_rows         = {dir_rows, row};
    endtask

    // Result side: check each popped record, then pick the next pop request
    always @(posedge i_clk) begin
        t_fb_rec want;
        if (i_rst_n && pop && !empty) begin
            if (feedback_due.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("MISMATCH feedback record %0h/%0h with nothing outstanding",
                             o_out_frame_seq, o_out_pkt_index);
                fail_count++;
            end else begin
                want = feedback_due.pop_front();
                if (o_out_frame_seq !== want.frame_seq)
                    note_mismatch("frame_seq", 64'(want.frame_seq), 64'(o_out_frame_seq));
                if (o_out_pkt_index !== want.pkt_index)
                    note_mismatch("pkt_index", 64'(want.pkt_index), 64'(o_out_pkt_index));
                if (o_out_rx_size !== want.rx_size)
                    note_mismatch("rx_size", 64'(want.rx_size), 64'(o_out_rx_size));
                if (o_arrival_offset_us !== want.offset)
                    note_mismatch("arrival_offset_us", 64'(unsigned'(want.offset)),
                                  64'(unsigned'(o_arrival_offset_us)));
                if (o_batch_len !== want.count)
                    note_mismatch("batch_len", 64'(want.count), 64'(o_batch_len));
                if (o_last_record !== want.last)
                    note_mismatch("last_record", 64'(want.last), 64'(o_last_record));
            end
        end
        pop <= !hold_pop && ($urandom_range(99) >= recv_idle);
    end

    // Long receiver hold-off so the banks fill and intake stalls
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_pop <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_pop <= 1'b0;
    end

    // Watchdog on cycles with no request moving anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (push && !full) || (pop && !empty)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    initial begin
        logic [6:0]  rnd_batch;
        logic [15:0] rnd_interval;
        logic        rnd_sink;
        logic [1:0]  cmd;
        logic [62:0] clock_us;
        int          pick;
        int          taken;
        int          phase;

        // State after reset
        pend_fill    = 0;
        epoch_us     = '0;
        epoch_set    = 1'b0;
        elapsed_ms   = '0;
        batch_sent   = 1'b0;
        cfg_batch    = 7'd20;
        cfg_interval = 16'd10;
        cfg_sink     = 1'b1;

        // Empty batch, tick and unused command before any packet
        add_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, 63'd0, 1, 0, 32'h0);
        add_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 63'd0, 1, 0, 32'h0);
        add_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 1, 0, 32'h0);
        // Single-record batches: epoch at all ones, then offset wrap and sign edges
        add_reg(REG_BATCH_COUNT, 32'd1);
        add_cmd(CMD_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 1, 1, 32'h0000_0000);
        add_cmd(CMD_PACKET, 16'h0000, 16'h0000, 16'h0000, 63'd0, 1, 1, 32'h0000_0001);
        add_cmd(CMD_PACKET, 16'h1234, 16'h0001, 16'h05DC, 63'h7FFF_FFFE, 1, 1,
                32'h7FFF_FFFF);
        add_cmd(CMD_PACKET, 16'h1235, 16'h0002, 16'h0040, 63'h7FFF_FFFF, 1, 1,
                32'h8000_0000);
        // Deadline on ticks, then a forced flush of two and of nothing
        add_reg(REG_BATCH_COUNT, 32'd3);
        add_reg(REG_MAX_INTERVAL, 32'd2);
        add_cmd(CMD_PACKET, 16'h0100, 16'h0000, 16'h0200, 63'h8000_1000, 0, 0, 32'h0);
        add_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        add_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        add_cmd(CMD_PACKET, 16'h0101, 16'h0001, 16'h0300, 63'h8000_2000, 0, 0, 32'h0);
        add_cmd(CMD_PACKET, 16'h0101, 16'h0002, 16'h0400, 63'h8000_3000, 0, 0, 32'h0);
        add_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        add_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, 63'd0, 1, 0, 32'h0);
        // Sink off: a full batch is dropped
        add_reg(REG_SINK_ENABLED, 32'd0);
        add_cmd(CMD_PACKET, 16'h0200, 16'h0000, 16'h0010, 63'h8000_4000, 1, 0, 32'h0);
        add_cmd(CMD_PACKET, 16'h0200, 16'h0001, 16'h0020, 63'h8000_5000, 1, 0, 32'h0);
        add_cmd(CMD_PACKET, 16'h0200, 16'h0002, 16'h0030, 63'h8000_6000, 1, 0, 32'h0);
        // Zero threshold falls back to the default, widest deadline
        add_reg(REG_SINK_ENABLED, 32'd1);
        add_reg(REG_BATCH_COUNT, 32'd0);
        add_reg(REG_MAX_INTERVAL, 32'd65535);
        add_cmd(CMD_PACKET, 16'h0300, 16'h0000, 16'h0050, 63'h8000_7000, 0, 0, 32'h0);
        add_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        add_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        // Threshold above capacity, then deadline met on a packet and on a tick
        add_reg(REG_BATCH_COUNT, 32'd127);
        add_cmd(CMD_PACKET, 16'h0400, 16'h0000, 16'h0060, 63'h8000_8000, 0, 0, 32'h0);
        add_cmd(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        add_reg(REG_MAX_INTERVAL, 32'd1);
        add_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);
        add_cmd(CMD_PACKET, 16'h0500, 16'h0000, 16'h0070, 63'h8000_9000, 0, 0, 32'h0);
        add_cmd(CMD_PACKET, 16'h0500, 16'h0001, 16'h0080, 63'h8000_A000, 0, 0, 32'h0);
        add_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 63'd0, 0, 0, 32'h0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                settle_block();
                write_register(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                send_command(dir_rows[r].command, dir_rows[r].frame_seq,
                             dir_rows[r].pkt_index, dir_rows[r].rx_size,
                             dir_rows[r].arrival_us, !dir_rows[r].typed);
                if (dir_rows[r].typed && dir_rows[r].typed_n == 1)
                    feedback_due = {feedback_due,
                                    t_fb_rec'{dir_rows[r].frame_seq,
                                              dir_rows[r].pkt_index,
                                              dir_rows[r].rx_size,
                                              dir_rows[r].typed_offset, 7'd1, 1'b1}};
            end
        end

        // Random part: three idling phases, four settings each
        clock_us = 63'h0000_0001_0000_0000;
        for (int rnd = 0; rnd < CFG_ROUNDS; rnd++) begin
            phase = rnd / 4;
            send_idle = (phase == 0) ? 31 : (phase == 1) ? 79 : 0;
            recv_idle = (phase == 0) ? 79 : (phase == 1) ? 31 : 0;
            if (rnd == 0) begin
                rnd_batch = 7'd64;  rnd_interval = 16'd0;     rnd_sink = 1'b1;
            end else if (rnd == 4) begin
                rnd_batch = 7'd127; rnd_interval = 16'hFFFF;  rnd_sink = 1'b1;
            end else if (rnd == 8) begin
                rnd_batch = 7'd2;   rnd_interval = 16'd0;     rnd_sink = 1'b1;
            end else begin
                rnd_batch = ($urandom_range(7) == 0) ? 7'($urandom)
                                                      : 7'($urandom_range(12, 1));
                rnd_interval = ($urandom_range(5) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(8));
                rnd_sink = ($urandom_range(5) != 0);
            end
            settle_block();
            write_register(REG_BATCH_COUNT, {25'd0, rnd_batch});
            write_register(REG_MAX_INTERVAL, {16'd0, rnd_interval});
            write_register(REG_SINK_ENABLED, {31'd0, rnd_sink});
            if (rnd == 8) pressure_go = 1'b1;

            taken = 0;
            while (taken < ITEMS_PER_ROUND) begin
                pick = $urandom_range(99);
                cmd  = (pick < 68) ? CMD_PACKET : (pick < 88) ? CMD_TICK :
                       (pick < 96) ? CMD_FLUSH : CMD_UNUSED;
                // Mostly a rising clock, now and then a jump anywhere
                if ($urandom_range(15) == 0)
                    clock_us = 63'({$urandom, $urandom});
                else
                    clock_us = clock_us + 63'($urandom_range(2000));
                send_command(cmd, 16'($urandom), 16'($urandom), 16'($urandom),
                             clock_us, 1'b1);
                if (cmd != CMD_UNUSED) taken++;
            end
        end

        settle_block();
        if (fail_count == 0 && feedback_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
